// File: rtl/core/mkdb_pkg.sv
// ----------------------------------------------------------------------------
// mkdb_pkg
// Types, register map and constants for the multi-key debouncer.
// ----------------------------------------------------------------------------
package mkdb_pkg;

  localparam int NUM_CHANNELS = 11;

  localparam int CH_W    = 4;
  localparam int MASK_W  = 11;
  localparam int COUNT_W = 8;
  localparam int TIME_W  = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [TIME_W-1:0] TIME_SAT   = 16'hFFFE;
  localparam logic [TIME_W-1:0] IDLE_RESET = 16'hFFFF;

  localparam logic [MASK_W-1:0]  ENABLE_RESET = 11'd2047;
  localparam logic [MASK_W-1:0]  ACTIVE_RESET = 11'd72;
  localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [TIME_W-1:0]  WINDOW_RESET = 16'd80;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_ACTIVE   = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;
  localparam logic [1:0] REG_WINDOW   = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            pin_level;
    logic            bus_ok;
  } sample_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic              pressed;
    logic              double_press;
    logic [TIME_W-1:0] press_ticks;
    logic [TIME_W-1:0] release_ticks;
  } status_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic               last_active;
    logic               pressed;
    logic               dbl;
    logic [TIME_W-1:0]  hold_time;
    logic [TIME_W-1:0]  idle_time;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    sample_count: '0,
    last_active:  1'b0,
    pressed:      1'b0,
    dbl:          1'b0,
    hold_time:    '0,
    idle_time:    IDLE_RESET
  };

endpackage

// File: rtl/core/multi_key_debouncer_with_hold_timers.sv
// ----------------------------------------------------------------------------
// multi_key_debouncer_with_hold_timers
// Per-channel key debouncer with press/release timers and double-press flag.
// ----------------------------------------------------------------------------
// Each sample word carries one tick of one key channel: channel, raw pin level
// and bus health. The block answers every sample with one status word holding
// the channel's debounced state after the update. Channels beyond the last
// report zero status and touch nothing.
// A sample passes the sample stage register and then the output register.
// One sample is taken every cycle while sample_stall is low, also on
// repeated samples of the same channel: the state table is read into a
// register at acceptance and written back as the sample leaves the sample
// stage, with the fresh entry bypassed when the next sample hits it. The
// status word sits in an output register; while the receiver stalls it
// holds, the sample pipeline stage behind it fills, and then sample_stall rises.
// Reset clears the pipeline, loads the register defaults and marks every
// table entry unwritten; an unwritten entry reads as its reset state, so no
// clearing pass is needed and samples are taken from the first cycle.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12; write them
// only while no sample is in flight.
// ----------------------------------------------------------------------------
module multi_key_debouncer_with_hold_timers #(
  parameter int NUM_CHANNELS = mkdb_pkg::NUM_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  mkdb_pkg::sample_word_t      sample,
  output logic                        status_valid,
  input  logic                        status_stall,
  output mkdb_pkg::status_word_t      status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mkdb_pkg::ADDR_W-1:0] paddr,
  input  logic [mkdb_pkg::DATA_W-1:0] pwdata,
  output logic [mkdb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [5:0] CH_LIMIT = 6'(NUM_CHANNELS);

  logic [mkdb_pkg::MASK_W-1:0]  enable_mask;
  logic [mkdb_pkg::MASK_W-1:0]  active_level_mask;
  logic [mkdb_pkg::COUNT_W-1:0] debounce_count;
  logic [mkdb_pkg::TIME_W-1:0]  double_press_window;

  mkdb_pkg::entry_t mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] written;

  logic                   s1_valid;
  mkdb_pkg::sample_word_t s1;
  mkdb_pkg::entry_t       rd;
  logic                   rd_written;

  logic                   accept;
  logic                   advance;
  logic                   in_range;
  logic                   s1_in_range;
  logic                   bypass;
  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       s1_idx;
  mkdb_pkg::entry_t       cur;
  mkdb_pkg::entry_t       upd;
  logic                   enabled;
  logic                   act;
  logic [15:0]            en_wide;
  logic [15:0]            act_wide;
  logic [mkdb_pkg::COUNT_W-1:0] cnt;
  logic                   hit;
  logic [mkdb_pkg::TIME_W-1:0]  idle_inc;
  mkdb_pkg::status_word_t status_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask         <= mkdb_pkg::ENABLE_RESET;
      active_level_mask   <= mkdb_pkg::ACTIVE_RESET;
      debounce_count      <= mkdb_pkg::DEBOUNCE_RESET;
      double_press_window <= mkdb_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        mkdb_pkg::REG_ENABLE:   enable_mask         <= pwdata[mkdb_pkg::MASK_W-1:0];
        mkdb_pkg::REG_ACTIVE:   active_level_mask   <= pwdata[mkdb_pkg::MASK_W-1:0];
        mkdb_pkg::REG_DEBOUNCE: debounce_count      <= pwdata[mkdb_pkg::COUNT_W-1:0];
        mkdb_pkg::REG_WINDOW:   double_press_window <= pwdata[mkdb_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mkdb_pkg::REG_ENABLE:   prdata = 32'(enable_mask);
      mkdb_pkg::REG_ACTIVE:   prdata = 32'(active_level_mask);
      mkdb_pkg::REG_DEBOUNCE: prdata = 32'(debounce_count);
      mkdb_pkg::REG_WINDOW:   prdata = 32'(double_press_window);
      default:                prdata = '0;
    endcase
  end

  assign advance      = s1_valid && (!status_valid || !status_stall);
  assign sample_stall = s1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  assign in_range    = {2'b00, sample.channel} < CH_LIMIT;
  assign s1_in_range = {2'b00, s1.channel} < CH_LIMIT;
  assign in_idx      = IDX_W'(sample.channel);
  assign s1_idx      = IDX_W'(s1.channel);
  assign bypass      = advance && s1_in_range && (s1.channel == sample.channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= sample;
    end
  end

  // table read at acceptance, bypassing the entry being written this edge
  always_ff @(posedge clk) begin
    if (advance && s1_in_range) begin
      mem[s1_idx] <= upd;
    end
    if (accept && in_range) begin
      rd <= bypass ? upd : mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (advance && s1_in_range) begin
        written[s1_idx] <= 1'b1;
      end
      if (accept && in_range) begin
        rd_written <= bypass || written[in_idx];
      end
    end
  end

  always_comb begin
    cur      = rd_written ? rd : mkdb_pkg::ENTRY_RESET;
    en_wide  = 16'(enable_mask);
    act_wide = 16'(active_level_mask);
    enabled  = en_wide[s1.channel];
    act      = s1.pin_level == act_wide[s1.channel];
    upd      = cur;
    cnt      = '0;
    hit      = 1'b0;
    idle_inc = cur.idle_time;
    if (enabled) begin
      if (act != cur.last_active) begin
        cnt = (act && !s1.bus_ok) ? '0 : cur.sample_count + 8'd1;
      end
      hit = cnt == debounce_count;
      upd.sample_count = hit ? '0 : cnt;
      if (hit) begin
        upd.pressed     = act;
        upd.last_active = act;
        if (act) begin
          upd.dbl = cur.idle_time <= double_press_window;
        end
      end
      if (upd.pressed) begin
        if (cur.hold_time < mkdb_pkg::TIME_SAT) begin
          upd.hold_time = cur.hold_time + 16'd1;
        end
        upd.idle_time = '0;
      end else begin
        upd.hold_time = '0;
        if (cur.idle_time < mkdb_pkg::TIME_SAT) begin
          idle_inc = cur.idle_time + 16'd1;
        end
        upd.idle_time = idle_inc;
        if (idle_inc > double_press_window) begin
          upd.dbl = 1'b0;
        end
      end
    end
  end

  always_comb begin
    status_next.out_channel = s1.channel;
    if (s1_in_range) begin
      status_next.pressed       = upd.pressed;
      status_next.double_press  = upd.dbl;
      status_next.press_ticks   = upd.hold_time;
      status_next.release_ticks = upd.idle_time;
    end else begin
      status_next.pressed       = 1'b0;
      status_next.double_press  = 1'b0;
      status_next.press_ticks   = '0;
      status_next.release_ticks = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= status_next;
    end
  end

endmodule

// File: verif/mkdb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkdb_checker
// Watches the sample, status and register ports of the multi-key debouncer,
// keeps its own copy of every channel's debounce state and the register set,
// works out the status word each accepted sample must produce and compares
// each accepted status word, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module mkdb_checker
  import mkdb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic                sample_stall,
  input  sample_word_t        sample,
  input  logic                status_valid,
  input  logic                status_stall,
  input  status_word_t        status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int                  mismatches,
  output int                  outstanding
);

  logic [MASK_W-1:0]  en_mask;
  logic [MASK_W-1:0]  act_mask;
  logic [COUNT_W-1:0] deb_thr;
  logic [TIME_W-1:0]  dp_window;

  logic [COUNT_W-1:0] cnt_q   [NUM_CHANNELS];
  logic               level_q [NUM_CHANNELS];
  logic               press_q [NUM_CHANNELS];
  logic               dbl_q   [NUM_CHANNELS];
  logic [TIME_W-1:0]  hold_q  [NUM_CHANNELS];
  logic [TIME_W-1:0]  idle_q  [NUM_CHANNELS];

  status_word_t status_due_q[$];
  status_word_t want;
  int           fail_cnt;

  function automatic status_word_t debounce_key(input sample_word_t s);
    status_word_t r;
    logic         act;
    int           c;
    r = '0;
    r.out_channel = s.channel;
    c = int'(s.channel);
    if (c >= NUM_CHANNELS) return r;
    if (en_mask[c]) begin
      act = (s.pin_level == act_mask[c]);
      if (act != level_q[c]) begin
        cnt_q[c] = cnt_q[c] + 1'b1;
        if (act && !s.bus_ok) cnt_q[c] = '0;
      end else begin
        cnt_q[c] = '0;
      end
      if (cnt_q[c] == deb_thr) begin
        cnt_q[c] = '0;
        if (act) dbl_q[c] = (idle_q[c] <= dp_window);
        press_q[c] = act;
        level_q[c] = act;
      end
      if (press_q[c]) begin
        if (hold_q[c] < TIME_SAT) hold_q[c] = hold_q[c] + 1'b1;
        idle_q[c] = '0;
      end else begin
        hold_q[c] = '0;
        if (idle_q[c] < TIME_SAT) idle_q[c] = idle_q[c] + 1'b1;
        if (idle_q[c] > dp_window) dbl_q[c] = 1'b0;
      end
    end
    r.pressed       = press_q[c];
    r.double_press  = dbl_q[c];
    r.press_ticks   = hold_q[c];
    r.release_ticks = idle_q[c];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      en_mask   = ENABLE_RESET;
      act_mask  = ACTIVE_RESET;
      deb_thr   = DEBOUNCE_RESET;
      dp_window = WINDOW_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cnt_q[c]   = '0;
        level_q[c] = 1'b0;
        press_q[c] = 1'b0;
        dbl_q[c]   = 1'b0;
        hold_q[c]  = '0;
        idle_q[c]  = IDLE_RESET;
      end
      status_due_q.delete();
      fail_cnt = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ENABLE: begin
            en_mask = pwdata[MASK_W-1:0];
          end
          REG_ACTIVE: begin
            act_mask = pwdata[MASK_W-1:0];
          end
          REG_DEBOUNCE: begin
            deb_thr = pwdata[COUNT_W-1:0];
          end
          REG_WINDOW: begin
            dp_window = pwdata[TIME_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (sample_valid && !sample_stall) status_due_q.push_back(debounce_key(sample));
      if (status_valid && !status_stall) begin
        if (status_due_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: status word ch=%0d with none outstanding", $realtime,
                     status.out_channel);
          fail_cnt++;
        end else begin
          want = status_due_q.pop_front();
          if (status.out_channel !== want.out_channel || status.pressed !== want.pressed ||
              status.double_press !== want.double_press ||
              status.press_ticks !== want.press_ticks ||
              status.release_ticks !== want.release_ticks) begin
            if (fail_cnt < 10)
              $display({"%0t: status mismatch exp ch=%0d p=%0d dp=%0d hold=%0d rel=%0d,",
                        " got ch=%0d p=%0d dp=%0d hold=%0d rel=%0d"},
                       $realtime, want.out_channel, want.pressed, want.double_press,
                       want.press_ticks, want.release_ticks, status.out_channel,
                       status.pressed, status.double_press, status.press_ticks,
                       status.release_ticks);
            fail_cnt++;
          end
        end
      end
      mismatches  <= fail_cnt;
      outstanding <= status_due_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-key debouncer. A short directed run on
// the reset registers covers out-of-range channels, a press blocked by a bad
// bus, press, release and a double press; presses and releases on a threshold
// of one then step both timers; random phases follow with changing register
// settings and sender and receiver idling, built mostly from runs of equal
// samples on one channel so that presses and releases get accepted.
// ----------------------------------------------------------------------------
module tb_top;
  import mkdb_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  sample_word_t        sample = '0;
  logic                status_valid;
  logic                status_stall = 1'b0;
  status_word_t        status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int                  mismatches;
  int                  outstanding;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  cur_deb = 5;
  int                  words_sent = 0;
  logic [CH_W-1:0]     last_ch = '0;

  always #2 clk = ~clk;

  multi_key_debouncer_with_hold_timers dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mkdb_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    status_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic push_word(input sample_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= w;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic push_run(input logic [CH_W-1:0] ch, input logic pin, input logic bus,
                          input int n);
    sample_word_t w;
    w.channel   = ch;
    w.pin_level = pin;
    w.bus_ok    = bus;
    repeat (n) push_word(w);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_phase(input int en, input int act, input int deb, input int win,
                           input int idle, input int stall);
    drain();
    write_reg(REG_ENABLE, en);
    write_reg(REG_ACTIVE, act);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_WINDOW, win);
    cur_deb = deb;
    send_idle_pct = idle;
    stall_pct <= stall;
  endtask

  // runs of one level on one channel, with glitches and bus drop-outs, or a single random word
  task automatic send_burst();
    sample_word_t w;
    logic         lvl;
    logic         shaky;
    int           len;
    if ($urandom_range(99) < 15) begin
      w.channel   = CH_W'($urandom_range(15));
      w.pin_level = 1'($urandom_range(1));
      w.bus_ok    = 1'($urandom_range(1));
      push_word(w);
    end else begin
      if ($urandom_range(99) >= 40) last_ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
      w.channel = last_ch;
      lvl   = 1'($urandom_range(1));
      shaky = ($urandom_range(99) < 30);
      len   = $urandom_range(cur_deb + 3, 1);
      for (int i = 0; i < len; i++) begin
        w.pin_level = lvl ^ ($urandom_range(99) < 4);
        w.bus_ok    = !(shaky && ($urandom_range(99) < 15));
        push_word(w);
      end
    end
  endtask

  task automatic run_random(input int quota);
    int stop_at;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) send_burst();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out-of-range channels, bus-blocked press, press, release, double press, then channels 0 and 10
    push_run(4'd15, 1'b1, 1'b1, 1);
    push_run(4'd11, 1'b0, 1'b0, 1);
    push_run(4'd3, 1'b1, 1'b0, 2);
    push_run(4'd3, 1'b1, 1'b1, 5);
    push_run(4'd3, 1'b0, 1'b0, 5);
    push_run(4'd3, 1'b1, 1'b1, 5);
    push_run(4'd0, 1'b1, 1'b1, 1);
    push_run(4'd10, 1'b0, 1'b1, 1);
    push_run(4'd10, 1'b1, 1'b0, 1);

    // press and release on a threshold of one
    set_phase(2047, 2047, 1, 65534, 0, 0);
    push_run(4'd0, 1'b1, 1'b1, 20);
    push_run(4'd0, 1'b0, 1'b1, 20);
    push_run(4'd0, 1'b1, 1'b1, 3);
    run_random(150);

    set_phase($urandom_range(2047), 0, 0, 0, 52, 0);
    run_random(150);
    set_phase(2047, $urandom_range(2047), 255, $urandom_range(65534), 0, 52);
    run_random(350);
    set_phase(0, $urandom_range(2047), 2, 40, 20, 20);
    run_random(60);
    set_phase($urandom_range(2047), $urandom_range(2047), $urandom_range(8, 1),
              $urandom_range(200), 0, 0);
    run_random(250);
    set_phase(2047, 72, 3, 80, 20, 20);
    run_random(250);

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/mkdb_pkg.sv
rtl/core/multi_key_debouncer_with_hold_timers.sv
verif/mkdb_checker.sv
verif/tb_top.sv
